// ===== sv/drc_pkg.sv =====
// ----------------------------------------------------------------------------
// Delta row compressor package
// Shared types, constants and helpers for the delta row compressor.
// ----------------------------------------------------------------------------
package drc_pkg;

   localparam int CHUNK_MAX    = 8;     // longest run in one command
   localparam int OFFSET_SAT   = 31;    // offset field saturation
   localparam int EXT_FULL     = 255;   // extension byte "more follows"
   localparam int ROW_HARD_MAX = 4096;  // hard cap on bytes per row
   localparam int CMD_SHIFT    = 5;     // count field position in command

   localparam int CNT_W  = 13;          // counters and row length
   localparam int BYTE_W = 8;

   // CSR register indexes
   localparam logic [1:0] REG_ROW_LENGTH = 2'd0;

   typedef enum logic [2:0] {
      EM_IDLE,
      EM_CMD,
      EM_EXT,
      EM_DATA,
      EM_END
   } em_state_type;

   // saturating increment of a 13 bit counter
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] r;
      r = v;
      if (v != {CNT_W{1'b1}}) begin
         r = v + 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== sv/drc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module drc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // read-before-write on a collision: old data
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/delta_row_compressor.sv =====
// Path: stage 1 register, emitter state register, output register.
// Throughput: one input beat per cycle while the emitter is idle; input
//   stalls while the emitter sends result beats or waits on rsp_ready.
// Previous-row bytes live in one RAM, read ahead of the compare.
// Reset (synchronous, active high) clears all control state; row_length = 1.
// ----------------------------------------------------------------------------
// Delta row compressor
// Delta row (mode 3) raster compression: compares each byte with the previous
// row, emits command, offset extension and replacement bytes per run.
// ----------------------------------------------------------------------------
module delta_row_compressor import drc_pkg::*; #(
   parameter int MAX_ROW_BYTES = 4096
) (
   input  logic              clock,
   input  logic              reset,
   // input beats
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_pixel_byte,
   input  logic              req_first_row,
   // result beats
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_no_data,
   output logic              rsp_row_end,
   output logic [12:0]       rsp_row_count,
   // CSR port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [1:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int AW      = $clog2(MAX_ROW_BYTES);
   localparam int LEN_CAP = (MAX_ROW_BYTES < ROW_HARD_MAX) ? MAX_ROW_BYTES : ROW_HARD_MAX;

   // ------------------------------------------------------------------------
   // CSR: single register, row_length
   // ------------------------------------------------------------------------
   logic [CNT_W-1:0] row_len_ff, row_len_in;

   assign pready = 1'b1;
   assign prdata = {{(32-CNT_W){1'b0}}, row_len_ff};

   always_comb begin
      row_len_in = row_len_ff;
      if (psel && penable && pwrite && (paddr == REG_ROW_LENGTH)) begin
         row_len_in = pwdata[CNT_W-1:0];
      end
   end

   // effective row length: 0 acts as 1, clamp to the store size and the hard cap
   logic [CNT_W-1:0] eff_len;
   always_comb begin
      eff_len = row_len_ff;
      if (eff_len == '0) begin
         eff_len = CNT_W'(1);
      end
      if (eff_len > CNT_W'(LEN_CAP)) begin
         eff_len = CNT_W'(LEN_CAP);
      end
   end

   // ------------------------------------------------------------------------
   // Control state
   // ------------------------------------------------------------------------
   logic [CNT_W-1:0]  position_ff, position_in;
   logic [CNT_W-1:0]  equal_run_ff, equal_run_in;
   logic [3:0]        diff_count_ff, diff_count_in;
   logic              continuing_ff, continuing_in;
   logic [BYTE_W-1:0] diff_buf_ff [CHUNK_MAX];

   // stage 1: item waiting for its previous-row byte / for the emitter
   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_first_ff;
   logic [AW-1:0]     s1_addr_ff;
   logic              s1_fwd_ff;     // store byte comes from the write in flight
   logic [BYTE_W-1:0] s1_fwd_data_ff;

   // flush snapshot for the emitter
   logic [3:0]        fl_n_ff, fl_n_in;
   logic [4:0]        fl_off_ff, fl_off_in;
   logic              fl_ext_ff, fl_ext_in;
   logic [CNT_W-1:0]  fl_rest_ff, fl_rest_in;
   logic              fl_end_ff, fl_end_in;
   logic [2:0]        fl_idx_ff, fl_idx_in;

   em_state_type      em_state_ff, em_state_in;
   logic [CNT_W-1:0]  emitted_ff, emitted_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_no_data_ff, rsp_no_data_in;
   logic              rsp_row_end_ff, rsp_row_end_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // ------------------------------------------------------------------------
   // Processing of the stage 1 item (only while emitter idle)
   // ------------------------------------------------------------------------
   logic              proc_now;
   logic              accept;
   logic [BYTE_W-1:0] ram_rd_data;
   logic [BYTE_W-1:0] stored;
   logic              differs;
   logic              row_done;
   logic              do_flush;
   logic              buf_we;
   logic [3:0]        cnt_inc;
   logic [CNT_W-1:0]  pos_next;
   logic [AW-1:0]     rd_addr;

   assign proc_now  = s1_valid_ff && (em_state_ff == EM_IDLE);
   assign req_ready = !s1_valid_ff || proc_now;
   assign accept    = req_valid && req_ready;

   assign stored   = s1_fwd_ff ? s1_fwd_data_ff : ram_rd_data;
   assign differs  = s1_first_ff || (stored != s1_byte_ff);
   assign row_done = ({1'b0, position_ff} + 14'd1) >= {1'b0, eff_len};
   assign cnt_inc  = diff_count_ff + 4'd1;

   always_comb begin
      position_in   = position_ff;
      equal_run_in  = equal_run_ff;
      diff_count_in = diff_count_ff;
      continuing_in = continuing_ff;
      do_flush      = 1'b0;
      buf_we        = 1'b0;
      fl_n_in       = fl_n_ff;
      fl_off_in     = fl_off_ff;
      fl_ext_in     = fl_ext_ff;
      fl_rest_in    = fl_rest_ff;
      fl_end_in     = fl_end_ff;

      if (proc_now) begin
         // offset info from the state before this byte
         fl_off_in  = continuing_ff ? 5'd0 :
                      (equal_run_ff >= CNT_W'(OFFSET_SAT)) ? 5'(OFFSET_SAT) :
                      equal_run_ff[4:0];
         fl_ext_in  = !continuing_ff && (equal_run_ff >= CNT_W'(OFFSET_SAT));
         fl_rest_in = equal_run_ff - CNT_W'(OFFSET_SAT);
         fl_end_in  = row_done;

         if (differs) begin
            buf_we = 1'b1;
            // a full chunk, or the pending run closing at the row end
            if (cnt_inc == 4'(CHUNK_MAX) || row_done) begin
               do_flush      = 1'b1;
               fl_n_in       = cnt_inc;
               diff_count_in = '0;
               equal_run_in  = '0;
               continuing_in = 1'b1;
            end else begin
               diff_count_in = cnt_inc;
            end
         end else begin
            if (diff_count_ff != '0) begin
               do_flush     = 1'b1;
               fl_n_in      = diff_count_ff;
               equal_run_in = CNT_W'(1);
            end else begin
               equal_run_in = sat_inc(equal_run_ff);
            end
            diff_count_in = '0;
            continuing_in = 1'b0;
         end

         if (row_done) begin
            position_in   = '0;
            equal_run_in  = '0;
            diff_count_in = '0;
            continuing_in = 1'b0;
         end else begin
            position_in = position_ff + 1'b1;
         end
      end
   end

   // the next item reads the position this cycle's item leaves behind
   assign pos_next = proc_now ? position_in : position_ff;
   assign rd_addr  = ({19'd0, pos_next} < 32'(MAX_ROW_BYTES)) ? AW'(pos_next) : '0;

   assign s1_valid_in = accept || (s1_valid_ff && !proc_now);

   drc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_ROW_BYTES)
   ) u_prev_row (
      .clock   (clock),
      .wr_en   (proc_now),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_byte_ff),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------------
   // Emitter: one result beat per cycle unless stalled, from the flush snapshot
   // ------------------------------------------------------------------------
   // extension rest counts down by 255 per full extension byte
   logic             rsp_fl_rest_upd;
   logic [CNT_W-1:0] fl_rest_nxt;
   assign fl_rest_nxt = rsp_fl_rest_upd ? (fl_rest_ff - CNT_W'(EXT_FULL)) : fl_rest_in;

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      em_state_in    = em_state_ff;
      fl_idx_in      = fl_idx_ff;
      emitted_in     = emitted_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_byte_in    = rsp_byte_ff;
      rsp_no_data_in = rsp_no_data_ff;
      rsp_row_end_in = rsp_row_end_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_fl_rest_upd = 1'b0;

      case (em_state_ff)
         EM_IDLE: begin
            fl_idx_in = '0;
            if (proc_now && do_flush) begin
               em_state_in = EM_CMD;
            end else if (proc_now && row_done) begin
               em_state_in = EM_END;
            end
         end
         EM_CMD: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_byte_in    = {3'(fl_n_ff - 4'd1), fl_off_ff};
               rsp_no_data_in = 1'b0;
               rsp_row_end_in = 1'b0;
               emitted_in     = sat_inc(emitted_ff);
               rsp_count_in   = sat_inc(emitted_ff);
               em_state_in    = fl_ext_ff ? EM_EXT : EM_DATA;
            end
         end
         EM_EXT: begin
            // 255 while more follows; a final value below 255 (0 if exact)
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_no_data_in = 1'b0;
               rsp_row_end_in = 1'b0;
               emitted_in     = sat_inc(emitted_ff);
               rsp_count_in   = sat_inc(emitted_ff);
               rsp_fl_rest_upd = 1'b1;
               if (fl_rest_ff >= CNT_W'(EXT_FULL)) begin
                  rsp_byte_in = 8'(EXT_FULL);
               end else begin
                  rsp_byte_in = fl_rest_ff[7:0];
                  em_state_in = EM_DATA;
               end
            end
         end
         EM_DATA: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_byte_in    = diff_buf_ff[fl_idx_ff];
               rsp_no_data_in = 1'b0;
               rsp_row_end_in = 1'b0;
               emitted_in     = sat_inc(emitted_ff);
               rsp_count_in   = sat_inc(emitted_ff);
               fl_idx_in      = fl_idx_ff + 3'd1;
               if ({1'b0, fl_idx_ff} == (fl_n_ff - 4'd1)) begin
                  em_state_in = fl_end_ff ? EM_END : EM_IDLE;
               end
            end
         end
         EM_END: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_byte_in    = '0;
               rsp_no_data_in = 1'b1;
               rsp_row_end_in = 1'b1;
               rsp_count_in   = emitted_ff;
               emitted_in     = '0;
               em_state_in    = EM_IDLE;
            end
         end
         default: begin
            em_state_in = EM_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         row_len_ff    <= CNT_W'(1);
         position_ff   <= '0;
         equal_run_ff  <= '0;
         diff_count_ff <= '0;
         continuing_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
         em_state_ff   <= EM_IDLE;
         emitted_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         row_len_ff    <= row_len_in;
         position_ff   <= position_in;
         equal_run_ff  <= equal_run_in;
         diff_count_ff <= diff_count_in;
         continuing_ff <= continuing_in;
         s1_valid_ff   <= s1_valid_in;
         em_state_ff   <= em_state_in;
         emitted_ff    <= emitted_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff     <= req_pixel_byte;
         s1_first_ff    <= req_first_row;
         s1_addr_ff     <= rd_addr;
         // same-entry write in this cycle is not yet visible to the read
         s1_fwd_ff      <= proc_now && (s1_addr_ff == rd_addr);
         s1_fwd_data_ff <= s1_byte_ff;
      end
      if (buf_we) begin
         diff_buf_ff[diff_count_ff[2:0]] <= s1_byte_ff;
      end
      fl_n_ff        <= fl_n_in;
      fl_off_ff      <= fl_off_in;
      fl_ext_ff      <= fl_ext_in;
      fl_rest_ff     <= fl_rest_nxt;
      fl_end_ff      <= fl_end_in;
      fl_idx_ff      <= fl_idx_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_no_data_ff <= rsp_no_data_in;
      rsp_row_end_ff <= rsp_row_end_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_no_data   = rsp_no_data_ff;
   assign rsp_row_end   = rsp_row_end_ff;
   assign rsp_row_count = rsp_count_ff;

endmodule

// ===== tb/delta_row_compressor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta row compressor testbench
// Feeds raster bytes over the req_ channel and compares every rsp_ beat with
// a local delta-row predictor. The run covers a short directed table, a seed
// row and two delta rows with saturated offsets, and random phases at many
// row lengths, with random stalls on both channels.
// ----------------------------------------------------------------------------
module delta_row_compressor_tb import drc_pkg::*; ();

   localparam int          ROW_STORE = 4096;          // MAX_ROW_BYTES of u_top
   localparam logic [12:0] COUNT_TOP = 13'h1FFF;      // counter saturation
   localparam logic [1:0]  ROW_LENGTH_ADDR = 2'(REG_ROW_LENGTH * 4);
   localparam int          EXT_ROW = 34;              // row for offset extensions

   // one beat of the compressed stream
   typedef struct packed {
      logic [7:0]  out_byte;
      logic        no_data;
      logic        row_end;
      logic [12:0] row_count;
   } stream_beat_type;

   typedef enum logic {STEP_BEAT, STEP_CSR} step_kind_type;

   // directed table row: a pixel beat or a row_length write; typed rows carry
   // the row_count of the row end beat they close
   typedef struct {
      step_kind_type kind;
      logic [12:0]   csr_value;
      logic [7:0]    pix;
      logic          first;
      bit            typed;
      logic [12:0]   end_count;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_pixel_byte = 8'd0;
   logic        req_first_row = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [7:0]  rsp_out_byte;
   logic        rsp_no_data;
   logic        rsp_row_end;
   logic [12:0] rsp_row_count;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [1:0]  paddr = 2'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   delta_row_compressor #(.MAX_ROW_BYTES(ROW_STORE)) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_byte (req_pixel_byte),
      .req_first_row  (req_first_row),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_no_data    (rsp_no_data),
      .rsp_row_end    (rsp_row_end),
      .rsp_row_count  (rsp_row_count),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor state: shadow of the row store, run tracking and row_length
   // ------------------------------------------------------------------------
   logic [7:0]  prior_row [ROW_STORE];
   bit          prior_known [ROW_STORE];   // entry written since reset
   logic [12:0] row_len_reg = 13'd1;
   logic [12:0] row_pos = '0;
   logic [12:0] same_run = '0;             // equal bytes since last run
   logic [7:0]  pend_bytes [CHUNK_MAX];
   logic [3:0]  pend_cnt = '0;
   logic        run_cont = 1'b0;           // pending bytes extend a run
   logic [12:0] row_emitted = '0;

   stream_beat_type stream_due[$];         // beats still owed by u_top

   int  fault_count = 0;
   int  beats_in = 0;
   int  beats_out = 0;
   int  rows_closed = 0;
   int  csr_writes = 0;
   int  longest_ext = 0;
   bit  calm = 1'b0;                       // no stalls in the closing stretch

   function automatic void flag_fault(input string what);
      fault_count++;
      if (fault_count <= 10) begin
         $display("[%0t] MISMATCH %s", $realtime, what);
      end
   endfunction

   function automatic void emit_byte(input logic [7:0] b);
      stream_beat_type r;
      if (row_emitted != COUNT_TOP) begin
         row_emitted = row_emitted + 1'b1;
      end
      r.out_byte  = b;
      r.no_data   = 1'b0;
      r.row_end   = 1'b0;
      r.row_count = row_emitted;
      stream_due.push_back(r);
   endfunction

   // send the pending run: command, offset extension, replacement bytes
   function automatic void flush_pending();
      logic [4:0] offs;
      int         rest;
      int         last_ext;
      int         piece;
      int         ext_n;
      if (pend_cnt == 0) begin
         return;
      end
      offs = '0;
      if (!run_cont) begin
         offs = (same_run >= OFFSET_SAT) ? 5'(OFFSET_SAT) : same_run[4:0];
      end
      emit_byte(8'((pend_cnt - 1) << CMD_SHIFT) | 8'(offs));
      if (!run_cont && offs == OFFSET_SAT) begin
         rest = same_run - OFFSET_SAT;
         last_ext = EXT_FULL;
         ext_n = 0;
         while (rest != 0) begin
            piece = (rest > EXT_FULL) ? EXT_FULL : rest;
            emit_byte(8'(piece));
            rest -= piece;
            last_ext = piece;
            ext_n++;
         end
         // a full last piece (or none at all) needs a closing zero
         if (last_ext == EXT_FULL) begin
            emit_byte(8'd0);
            ext_n++;
         end
         if (ext_n > longest_ext) begin
            longest_ext = ext_n;
         end
      end
      for (int i = 0; i < pend_cnt; i++) begin
         emit_byte(pend_bytes[i]);
      end
      pend_cnt = '0;
      same_run = '0;
      run_cont = 1'b1;
   endfunction

   // one accepted pixel beat: update the shadow state, queue what it causes
   function automatic void compress_byte(input logic [7:0] pix, input logic first);
      logic [12:0]     eff;
      logic            differs;
      int              idx;
      stream_beat_type fin;
      eff = row_len_reg;
      if (eff == 0) begin
         eff = 13'd1;
      end
      if (eff > ROW_STORE) begin
         eff = 13'(ROW_STORE);
      end
      if (eff > ROW_HARD_MAX) begin
         eff = 13'(ROW_HARD_MAX);
      end
      idx = (row_pos < ROW_STORE) ? int'(row_pos) : 0;

      differs = first || (prior_row[idx] != pix);
      prior_row[idx] = pix;
      prior_known[idx] = 1'b1;

      if (differs) begin
         if (pend_cnt < CHUNK_MAX) begin
            pend_bytes[pend_cnt] = pix;
            pend_cnt = pend_cnt + 1'b1;
         end
         if (pend_cnt >= CHUNK_MAX) begin
            flush_pending();
         end
      end else begin
         flush_pending();
         run_cont = 1'b0;
         if (same_run != COUNT_TOP) begin
            same_run = same_run + 1'b1;
         end
      end

      row_pos = row_pos + 1'b1;
      if (row_pos >= eff) begin
         // trailing equal bytes are dropped, only pending bytes go out
         flush_pending();
         fin.out_byte  = 8'd0;
         fin.no_data   = 1'b1;
         fin.row_end   = 1'b1;
         fin.row_count = row_emitted;
         stream_due.push_back(fin);
         rows_closed++;
         row_pos     = '0;
         same_run    = '0;
         pend_cnt    = '0;
         run_cont    = 1'b0;
         row_emitted = '0;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Result side: random ready bursts, scoreboard at the rising edge
   // ------------------------------------------------------------------------
   int hold_left = 0;
   int quiet_left = 0;

   always @(negedge clock) begin
      int r;
      r = $urandom_range(0, 63);
      if (reset || calm) begin
         rsp_ready <= 1'b1;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (quiet_left != 0) begin
         rsp_ready <= 1'b1;
         quiet_left <= quiet_left - 1;
      end else if (r < 8) begin
         // stall starting with this one; hold_left keeps its remaining length
         rsp_ready <= 1'b0;
         hold_left <= $urandom_range(0, 16);
      end else begin
         rsp_ready <= 1'b1;
         if (r == 8) begin
            quiet_left <= $urandom_range(30, 150);
         end
      end
   end

   always @(posedge clock) begin
      stream_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_out++;
         if (stream_due.size() == 0) begin
            flag_fault($sformatf("unexpected beat: byte %h no_data %b end %b cnt %0d",
                                 rsp_out_byte, rsp_no_data, rsp_row_end, rsp_row_count));
         end else begin
            want = stream_due.pop_front();
            if (rsp_out_byte !== want.out_byte || rsp_no_data !== want.no_data ||
                rsp_row_end !== want.row_end || rsp_row_count !== want.row_count) begin
               flag_fault($sformatf({"beat %0d: want byte %h no_data %b end %b cnt %0d,",
                                     " got byte %h no_data %b end %b cnt %0d"},
                                    beats_out, want.out_byte, want.no_data,
                                    want.row_end, want.row_count, rsp_out_byte,
                                    rsp_no_data, rsp_row_end, rsp_row_count));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Input side
   // ------------------------------------------------------------------------
   int          send_quiet = 0;
   bit          pin_end = 1'b0;            // next beat closes a row, count typed in
   logic [12:0] pin_count = '0;

   task automatic wait_drained();
      while (stream_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // drive one beat from a falling edge, hold until taken, then maybe idle
   task automatic send_pixel(input logic [7:0] pix, input logic first);
      req_valid      = 1'b1;
      req_pixel_byte = pix;
      req_first_row  = first;
      do @(posedge clock); while (!req_ready);
      compress_byte(pix, first);
      // the row end beat just queued cannot have been taken yet
      if (pin_end) begin
         stream_due[stream_due.size() - 1].row_count = pin_count;
         pin_end = 1'b0;
      end
      beats_in++;
      @(negedge clock);
      if (send_quiet != 0) begin
         send_quiet--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end else if ($urandom_range(0, 39) == 0) begin
         send_quiet = $urandom_range(20, 100);
      end
   endtask

   // byte equal to or different from the stored one at the next position
   task automatic send_kind(input bit same);
      logic [7:0] stored;
      stored = prior_row[row_pos];
      if (same) begin
         send_pixel(stored, 1'b0);
      end else begin
         send_pixel(stored ^ 8'($urandom_range(1, 255)), 1'b0);
      end
   endtask

   // row_length write while idle, followed by a read back
   task automatic write_row_length(input logic [12:0] value);
      req_valid = 1'b0;
      wait_drained();
      // a beat that caused nothing may still be in flight
      repeat (10) @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = ROW_LENGTH_ADDR;
      pwdata  = {19'd0, value};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      row_len_reg = value;
      csr_writes++;
      @(negedge clock);
      pwrite  = 1'b0;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {19'd0, value}) begin
         flag_fault($sformatf("row_length read back %h, wrote %h", prdata, value));
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   table_row_type steps[$];

   task automatic add_step(input step_kind_type kind, input logic [12:0] csr_value,
                           input logic [7:0] pix, input logic first,
                           input bit typed, input logic [12:0] end_count);
      table_row_type t;
      t.kind      = kind;
      t.csr_value = csr_value;
      t.pix       = pix;
      t.first     = first;
      t.typed     = typed;
      t.end_count = end_count;
      steps.push_back(t);
   endtask

   // equal / differing run lengths of the two delta rows after the seed row
   int eq_seg [2] = '{31, 32};
   int df_seg [2] = '{3, 2};

   initial begin
      int          rand_items;
      int          pick;
      int          n;
      int          run_left;
      bit          run_same;
      logic [12:0] len_pick;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed table -----------------------------------------------
      // row_length 1 after reset: every beat is its own row
      add_step(STEP_BEAT, 13'd0, 8'h00, 1'b1, 1'b1, 13'd2);
      add_step(STEP_BEAT, 13'd0, 8'hFF, 1'b1, 1'b1, 13'd2);
      add_step(STEP_BEAT, 13'd0, 8'hFF, 1'b0, 1'b1, 13'd0);  // equal: empty row
      add_step(STEP_BEAT, 13'd0, 8'hAA, 1'b0, 1'b1, 13'd2);
      // zero length acts as one
      add_step(STEP_CSR,  13'd0, 8'h00, 1'b0, 1'b0, 13'd0);
      add_step(STEP_BEAT, 13'd0, 8'h55, 1'b0, 1'b1, 13'd2);
      // eight byte seed row: one full chunk, then a sparse delta row
      add_step(STEP_CSR,  13'd8, 8'h00, 1'b0, 1'b0, 13'd0);
      add_step(STEP_BEAT, 13'd0, 8'h01, 1'b1, 1'b0, 13'd0);
      add_step(STEP_BEAT, 13'd0, 8'h80, 1'b1, 1'b0, 13'd0);
      add_step(STEP_BEAT, 13'd0, 8'h7F, 1'b1, 1'b0, 13'd0);
      add_step(STEP_BEAT, 13'd0, 8'hFE, 1'b1, 1'b0, 13'd0);
      add_step(STEP_BEAT, 13'd0, 8'h10, 1'b1, 1'b0, 13'd0);
      add_step(STEP_BEAT, 13'd0, 8'h20, 1'b1, 1'b0, 13'd0);
      add_step(STEP_BEAT, 13'd0, 8'h40, 1'b1, 1'b0, 13'd0);
      add_step(STEP_BEAT, 13'd0, 8'h08, 1'b1, 1'b1, 13'd9);
      add_step(STEP_BEAT, 13'd0, 8'h01, 1'b0, 1'b0, 13'd0);
      add_step(STEP_BEAT, 13'd0, 8'h80, 1'b0, 1'b0, 13'd0);
      add_step(STEP_BEAT, 13'd0, 8'h33, 1'b0, 1'b0, 13'd0);
      add_step(STEP_BEAT, 13'd0, 8'hFE, 1'b0, 1'b0, 13'd0);
      add_step(STEP_BEAT, 13'd0, 8'h10, 1'b0, 1'b0, 13'd0);
      add_step(STEP_BEAT, 13'd0, 8'h20, 1'b0, 1'b0, 13'd0);
      add_step(STEP_BEAT, 13'd0, 8'h40, 1'b0, 1'b0, 13'd0);
      add_step(STEP_BEAT, 13'd0, 8'hC8, 1'b0, 1'b0, 13'd0);
      // shrink the row while already past the new end
      add_step(STEP_CSR,  13'd12, 8'h00, 1'b0, 1'b0, 13'd0);
      add_step(STEP_BEAT, 13'd0, 8'h11, 1'b1, 1'b0, 13'd0);
      add_step(STEP_BEAT, 13'd0, 8'h22, 1'b1, 1'b0, 13'd0);
      add_step(STEP_BEAT, 13'd0, 8'h33, 1'b1, 1'b0, 13'd0);
      add_step(STEP_BEAT, 13'd0, 8'h44, 1'b1, 1'b0, 13'd0);
      add_step(STEP_CSR,  13'd3, 8'h00, 1'b0, 1'b0, 13'd0);
      add_step(STEP_BEAT, 13'd0, 8'h66, 1'b0, 1'b1, 13'd6);

      foreach (steps[i]) begin
         if (steps[i].kind == STEP_CSR) begin
            write_row_length(steps[i].csr_value);
         end else begin
            // typed rows pin the row end count by hand
            pin_end   = steps[i].typed;
            pin_count = steps[i].end_count;
            send_pixel(steps[i].pix, steps[i].first);
         end
      end

      // --- saturated offsets --------------------------------------------
      // widest value reads back in full; no beat is sent at that length
      write_row_length(13'h1FFF);
      // seed row
      write_row_length(13'(EXT_ROW));
      repeat (EXT_ROW) send_pixel(8'($urandom_range(0, 255)), 1'b1);
      // offset 31 closed by a zero, then one extension byte below 255
      for (int k = 0; k < 2; k++) begin
         repeat (eq_seg[k]) send_kind(1'b1);
         repeat (df_seg[k]) send_kind(1'b0);
      end

      // --- random phases ------------------------------------------------
      rand_items = 0;
      run_left = 0;
      run_same = 1'b0;
      while (rand_items < 25) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            len_pick = 13'd0;
         end else if (pick <= 4) begin
            len_pick = 13'($urandom_range(1, 8));
         end else if (pick <= 8) begin
            len_pick = 13'($urandom_range(9, 40));
         end else begin
            len_pick = 13'($urandom_range(9, 64));
         end
         write_row_length(len_pick);
         n = $urandom_range(1, 40);
         repeat (n) begin
            if (rand_items >= 15) begin
               calm = 1'b1;
            end
            if (run_left == 0) begin
               run_same = $urandom_range(0, 1);
               run_left = $urandom_range(1, 12);
            end
            run_left--;
            if (!prior_known[row_pos] || $urandom_range(0, 15) == 0) begin
               send_pixel(8'($urandom_range(0, 255)), 1'b1);
            end else begin
               send_kind(run_same);
            end
            rand_items++;
            // now and then hold off until u_top has caught up
            if (!calm && $urandom_range(0, 24) == 0) begin
               req_valid = 1'b0;
               wait_drained();
            end
         end
      end

      // --- wind down ----------------------------------------------------
      req_valid = 1'b0;
      wait_drained();
      repeat (10) @(negedge clock);
      $display("Sent %0d pixel beats, checked %0d stream beats over %0d rows.",
               beats_in, beats_out, rows_closed);
      $display("%0d row_length writes (0 to 8191); longest offset extension %0d bytes.",
               csr_writes, longest_ext);
      if (fault_count == 0) begin
         $display("delta_row_compressor verification clean");
      end else begin
         $display("%0d mismatches in total", fault_count);
         $display("delta_row_compressor verification failed");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #30_000_000;
      $display("timeout with %0d beats still owed", stream_due.size());
      $display("delta_row_compressor verification failed");
      $finish;
   end

endmodule
